/* sv/cdq_pkg.sv */
// cdq_pkg: shared types and constants of the circular deque with minimum search
// holds the command and result structs, opcode and status codes
// no dependencies
`default_nettype none

package cdq_pkg;

  localparam int unsigned DEPTH_DEFAULT = 1024;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned COUNT_W       = 11;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_BACK  = 3'd5,
    OP_MIN        = 3'd6,
    OP_NOP        = 3'd7
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_READ = 2'd1,
    S_SCAN = 2'd2
  } state_e;

  localparam logic signed [DATA_W-1:0] DATA_FAIL = '1;

  typedef struct packed {
    logic [2:0]               opcode;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [1:0]               status;
    logic [COUNT_W-1:0]       count;
    logic                     is_empty;
  } res_t;

endpackage

`default_nettype wire

/* sv/circular_deque_with_min.sv */
// Double-ended queue of signed 32-bit words in a circular RAM of DEPTH entries,
// with push/pop/peek at both ends and a minimum search over all held words.
// One command is taken when start_i is high and busy_o is low; exactly one result
// follows, shown on res_o for one cycle with done_o high. Pushes, failed operations
// and the no-op give their result in the next cycle and leave busy_o low, so a new
// command can follow at once. Pops and peeks pass through S_READ for the RAM's
// registered read. The minimum search streams the held entries through the RAM
// read port one per cycle in S_SCAN. No result can be held off.
// depends on cdq_pkg and cdq_ram
`default_nettype none

module circular_deque_with_min #(
  parameter int unsigned DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire cdq_pkg::cmd_t cmd_i,
  output logic               busy_o,
  output logic               done_o,
  output cdq_pkg::res_t      res_o
);

  import cdq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  state_e state_q, state_d;
  logic [AW-1:0] head_q, head_d, tail_q, tail_d, pos_q, pos_d;
  logic [CW-1:0] cnt_q, cnt_d, left_q, left_d;
  logic          first_q, first_d;
  logic signed [DATA_W-1:0] best_q, best_d;
  logic          done_q, done_d;
  res_t          res_q, res_d;

  logic [AW-1:0] head_inc, head_dec, tail_inc, tail_dec, pos_inc;
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic signed [DATA_W-1:0] rdata, cand, res_data;
  logic [1:0]    res_status;
  logic [CW+COUNT_W-1:0] cnt_ext;
  logic          accept;
  opcode_e       op;

  assign accept = start_i && (state_q == S_IDLE);
  assign op     = opcode_e'(cmd_i.opcode);

  assign head_inc = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
  assign head_dec = (head_q == '0) ? LAST_IDX : head_q - 1'b1;
  assign tail_inc = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
  assign tail_dec = (tail_q == '0) ? LAST_IDX : tail_q - 1'b1;
  assign pos_inc  = (pos_q == LAST_IDX) ? '0 : pos_q + 1'b1;

  cdq_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (cmd_i.value),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // running minimum; the first word of a scan seeds it
  assign cand = (first_q || (rdata < best_q)) ? rdata : best_q;

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    tail_d     = tail_q;
    cnt_d      = cnt_q;
    pos_d      = pos_q;
    left_d     = left_q;
    first_d    = first_q;
    best_d     = best_q;
    we         = 1'b0;
    waddr      = tail_q;
    re         = 1'b0;
    raddr      = head_q;
    done_d     = 1'b0;
    res_data   = '0;
    res_status = ST_OK;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              done_d = 1'b1;
              if (cnt_q >= FULL_CNT) begin
                res_data   = DATA_FAIL;
                res_status = ST_FULL;
              end else begin
                we    = 1'b1;
                cnt_d = cnt_q + 1'b1;
                if (op == OP_PUSH_FRONT) begin
                  waddr  = head_dec;
                  head_d = head_dec;
                end else begin
                  waddr  = tail_q;
                  tail_d = tail_inc;
                end
              end
            end
            OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK, OP_MIN: begin
              if (cnt_q == '0) begin
                done_d     = 1'b1;
                res_data   = DATA_FAIL;
                res_status = ST_EMPTY;
              end else begin
                re      = 1'b1;
                state_d = S_READ;
                case (op)
                  OP_POP_FRONT: begin
                    raddr  = head_q;
                    head_d = head_inc;
                    cnt_d  = cnt_q - 1'b1;
                  end
                  OP_POP_BACK: begin
                    raddr  = tail_dec;
                    tail_d = tail_dec;
                    cnt_d  = cnt_q - 1'b1;
                  end
                  OP_PEEK_BACK: begin
                    raddr = tail_dec;
                  end
                  OP_MIN: begin
                    raddr   = head_q;
                    pos_d   = head_inc;
                    left_d  = cnt_q;
                    first_d = 1'b1;
                    state_d = S_SCAN;
                  end
                  default: begin
                    raddr = head_q;
                  end
                endcase
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        done_d   = 1'b1;
        res_data = rdata;
        state_d  = S_IDLE;
      end
      S_SCAN: begin
        best_d  = cand;
        first_d = 1'b0;
        left_d  = left_q - 1'b1;
        if (left_q > CW'(1)) begin
          re    = 1'b1;
          raddr = pos_q;
          pos_d = pos_inc;
        end else begin
          done_d   = 1'b1;
          res_data = cand;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // count field is the low bits of the held count
  assign cnt_ext = {{COUNT_W{1'b0}}, cnt_d};

  always_comb begin
    res_d.data     = res_data;
    res_d.status   = res_status;
    res_d.count    = cnt_ext[COUNT_W-1:0];
    res_d.is_empty = (cnt_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      cnt_q   <= '0;
      left_q  <= '0;
      first_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      cnt_q   <= cnt_d;
      left_q  <= left_d;
      first_q <= first_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    best_q <= best_d;
    if (done_d) begin
      res_q <= res_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FULL_CNT)
    else $error("held count above depth");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q <= LAST_IDX) && (tail_q <= LAST_IDX))
    else $error("index out of range");

  a_read_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ |=> done_q && state_q == S_IDLE)
    else $error("read did not finish in one cycle");

  a_scan_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && left_q == CW'(1)) |=> done_q && state_q == S_IDLE)
    else $error("scan end without result");

  a_push_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) && cnt_q < FULL_CNT)
    |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("push transfer did not grow count");

endmodule

`default_nettype wire

/* sv/cdq_ram.sv */
// cdq_ram: generic single-clock RAM, one write port and one registered read port
// width and depth set by parameters, no dependencies
`default_nettype none

module cdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* tb/circular_deque_with_min_check.sv */
`timescale 1ns / 1ps
// checker for circular_deque_with_min: watches the command and result transfers,
// keeps its own deque to predict each result and compares field by field
// depends on cdq_pkg
module circular_deque_with_min_check #(
  parameter int unsigned DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  cdq_pkg::cmd_t cmd_i,
  input  logic          busy_o,
  input  logic          done_o,
  input  cdq_pkg::res_t res_o,
  output int            err_count_o,
  output int            outstanding_o
);
  import cdq_pkg::*;

  logic signed [DATA_W-1:0] slot_mem [DEPTH];
  int unsigned front_ptr;
  int unsigned back_ptr;
  int unsigned fill_cnt;
  res_t        due_results [$];
  res_t        oldest;

  function automatic int unsigned ptr_next(int unsigned p);
    return (p + 1 >= DEPTH) ? 0 : p + 1;
  endfunction

  function automatic int unsigned ptr_prev(int unsigned p);
    return (p == 0) ? DEPTH - 1 : p - 1;
  endfunction

  // applies one command to the deque and returns the result it should give
  function automatic res_t deque_result(cmd_t c);
    res_t                     r;
    int unsigned              last;
    int unsigned              pos;
    logic signed [DATA_W-1:0] lowest;
    r.data   = '0;
    r.status = ST_OK;
    case (opcode_e'(c.opcode))
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (fill_cnt >= DEPTH) begin
          r.data   = DATA_FAIL;
          r.status = ST_FULL;
        end else if (opcode_e'(c.opcode) == OP_PUSH_FRONT) begin
          front_ptr = ptr_prev(front_ptr);
          slot_mem[front_ptr] = c.value;
          fill_cnt++;
        end else begin
          slot_mem[back_ptr] = c.value;
          back_ptr = ptr_next(back_ptr);
          fill_cnt++;
        end
      end
      OP_NOP: ;
      default: begin
        if (fill_cnt == 0) begin
          r.data   = DATA_FAIL;
          r.status = ST_EMPTY;
        end else begin
          last = ptr_prev(back_ptr);
          case (opcode_e'(c.opcode))
            OP_POP_FRONT: begin
              r.data    = slot_mem[front_ptr];
              front_ptr = ptr_next(front_ptr);
              fill_cnt--;
            end
            OP_POP_BACK: begin
              r.data   = slot_mem[last];
              back_ptr = last;
              fill_cnt--;
            end
            OP_PEEK_FRONT: r.data = slot_mem[front_ptr];
            OP_PEEK_BACK:  r.data = slot_mem[last];
            default: begin
              // scan front to back, signed compare
              lowest = slot_mem[front_ptr];
              pos    = front_ptr;
              for (int unsigned i = 1; i < fill_cnt; i++) begin
                pos = ptr_next(pos);
                if (slot_mem[pos] < lowest) lowest = slot_mem[pos];
              end
              r.data = lowest;
            end
          endcase
        end
      end
    endcase
    r.count    = fill_cnt[COUNT_W-1:0];
    r.is_empty = (fill_cnt == 0);
    return r;
  endfunction

  task automatic compare_result(res_t want, res_t got);
    if (got.data !== want.data) begin
      $error("data: expected %0d, got %0d", want.data, got.data);
      err_count_o++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      err_count_o++;
    end
    if (got.count !== want.count) begin
      $error("count: expected %0d, got %0d", want.count, got.count);
      err_count_o++;
    end
    if (got.is_empty !== want.is_empty) begin
      $error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
      err_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_ptr     = 0;
      back_ptr      = 0;
      fill_cnt      = 0;
      due_results.delete();
      err_count_o   = 0;
      outstanding_o = 0;
    end else begin
      // a result never belongs to a command taken at the same edge
      if (done_o === 1'b1) begin
        if (due_results.size() == 0) begin
          $error("result transfer with no command outstanding");
          err_count_o++;
        end else begin
          oldest = due_results[0];
          due_results.delete(0);
          compare_result(oldest, res_o);
        end
      end
      if (start_i === 1'b1 && busy_o === 1'b0) begin
        due_results.insert(due_results.size(), deque_result(cmd_i));
      end
      outstanding_o = due_results.size();
    end
  end

endmodule

/* tb/circular_deque_with_min_test.sv */
`timescale 1ns / 1ps
// top of the circular_deque_with_min testbench: clock, reset, command stimulus,
// watchdog and verdict; checking is done by circular_deque_with_min_check
// depends on cdq_pkg, circular_deque_with_min and circular_deque_with_min_check
module circular_deque_with_min_test;
  import cdq_pkg::*;

  localparam int unsigned DEPTH       = DEPTH_DEFAULT;
  localparam int          STALL_LIMIT = 6000;
  localparam int          TOTAL_CMDS  = 1200;
  localparam int          FILL_AFTER  = 60;
  localparam int unsigned DRAIN_CNT   = 64;

  logic clk_i   = 1'b0;
  logic rst_ni  = 1'b0;
  logic start_i = 1'b0;
  cmd_t cmd_i   = '0;
  logic busy_o;
  logic done_o;
  res_t res_o;

  int          err_count;
  int          outstanding;
  int          idle_cycles;
  int unsigned level;
  int          sent;
  int          directed_cnt;
  int          random_cnt;
  int          gap_mode;
  bit          filled;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  circular_deque_with_min #(.DEPTH(DEPTH)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .cmd_i  (cmd_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .res_o  (res_o)
  );

  circular_deque_with_min_check #(.DEPTH(DEPTH)) checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .cmd_i        (cmd_i),
    .busy_o       (busy_o),
    .done_o       (done_o),
    .res_o        (res_o),
    .err_count_o  (err_count),
    .outstanding_o(outstanding)
  );

  // watchdog: cycles with neither a command nor a result transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic logic signed [DATA_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -32'sd1;
      4, 5:    return $signed($urandom_range(0, 200)) - 100;
      default: return $signed($urandom);
    endcase
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    case (gap_mode)
      0:       return 0;
      1:       return (r < 60) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(8, 40);
      default: return (r < 25) ? 0 : (r < 85) ? $urandom_range(1, 4) : $urandom_range(10, 40);
    endcase
  endfunction

  // push_pct sets the drift of the fill level
  function automatic opcode_e pick_op(int push_pct);
    int m;
    if ($urandom_range(0, 99) < push_pct)
      return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
    m = $urandom_range(0, 19);
    if (m < 10) return m[0] ? OP_POP_FRONT : OP_POP_BACK;
    if (m < 15) return m[0] ? OP_PEEK_FRONT : OP_PEEK_BACK;
    if (m < 18) return OP_MIN;
    return OP_NOP;
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic issue(opcode_e op, logic signed [DATA_W-1:0] val);
    start_i <= 1'b1;
    cmd_i   <= '{opcode: op, value: val};
    do @(posedge clk_i); while (busy_o !== 1'b0);
    @(negedge clk_i);
    sent++;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: if (level < DEPTH) level++;
      OP_POP_FRONT, OP_POP_BACK:   if (level > 0) level--;
      default: ;
    endcase
  endtask

  task automatic hold_off(int n);
    if (n > 0) begin
      start_i <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    @(negedge clk_i);
    while (outstanding != 0) @(negedge clk_i);
  endtask

  // fill to the limit, hit it, then pop a stretch from both ends
  task automatic fill_and_drain();
    int m;
    wait_drained();
    gap_mode = 0;
    while (level < DEPTH) issue($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK, rand_word());
    issue(OP_PUSH_FRONT, rand_word());
    issue(OP_PUSH_BACK, rand_word());
    issue(OP_MIN, rand_word());
    issue(OP_PEEK_FRONT, rand_word());
    issue(OP_PEEK_BACK, rand_word());
    issue(OP_NOP, rand_word());
    gap_mode = 1;
    while (level > DEPTH - DRAIN_CNT) begin
      m = $urandom_range(0, 99);
      if (m < 90) issue(m[0] ? OP_POP_FRONT : OP_POP_BACK, rand_word());
      else if (m < 97) issue(m[0] ? OP_PEEK_FRONT : OP_PEEK_BACK, rand_word());
      else issue(OP_MIN, rand_word());
      hold_off(gap_len());
    end
    issue(OP_POP_BACK, rand_word());
    issue(OP_MIN, rand_word());
  endtask

  initial begin
    int push_pct;
    int len;
    level      = 0;
    sent       = 0;
    random_cnt = 0;
    filled     = 1'b0;
    gap_mode   = 0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reads on empty, extremes, wrap of the front index below zero
    issue(OP_NOP, 32'sh7fff_ffff);
    issue(OP_POP_FRONT, 32'sh8000_0000);
    issue(OP_POP_BACK, -32'sd1);
    issue(OP_PEEK_FRONT, '0);
    issue(OP_PEEK_BACK, rand_word());
    issue(OP_MIN, rand_word());
    issue(OP_PUSH_FRONT, 32'sh7fff_ffff);
    issue(OP_PUSH_BACK, 32'sh8000_0000);
    issue(OP_PUSH_FRONT, '0);
    issue(OP_PUSH_BACK, -32'sd1);
    issue(OP_PEEK_FRONT, rand_word());
    issue(OP_PEEK_BACK, rand_word());
    issue(OP_MIN, rand_word());
    issue(OP_POP_BACK, rand_word());
    issue(OP_MIN, rand_word());
    issue(OP_POP_FRONT, rand_word());
    issue(OP_NOP, rand_word());
    issue(OP_POP_FRONT, rand_word());
    issue(OP_PEEK_BACK, rand_word());
    issue(OP_POP_BACK, rand_word());
    issue(OP_POP_BACK, rand_word());
    issue(OP_MIN, rand_word());
    directed_cnt = sent;
    wait_drained();

    while (sent < TOTAL_CMDS) begin
      if (level > 300)    push_pct = 20;
      else if (level < 3) push_pct = 65;
      else case ($urandom_range(0, 2))
        0:       push_pct = 25;
        1:       push_pct = 45;
        default: push_pct = 65;
      endcase
      len      = $urandom_range(10, 60);
      gap_mode = $urandom_range(0, 2);
      repeat (len) begin
        issue(pick_op(push_pct), rand_word());
        random_cnt++;
        hold_off(gap_len());
      end
      if (!filled && random_cnt >= FILL_AFTER) begin
        fill_and_drain();
        filled = 1'b1;
      end else if ($urandom_range(0, 4) == 0) begin
        wait_drained();
      end
    end

    wait_drained();
    repeat (8) @(negedge clk_i);
    $display("run covered %0d commands (%0d directed), every opcode including the no-op,",
             sent, directed_cnt);
    $display("a fill to %0d entries with full and empty rejects and wrap at both ends", DEPTH);
    if (err_count == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
